// ===== rtl/dmq_pkg.sv =====
// shared types and constants for the digraph matrix query engine
`default_nettype none
package dmq_pkg;
   localparam int MaxVertices = 64;
   localparam int VertexWidth = $clog2(MaxVertices);

   typedef enum logic [2:0] {
      CMD_INSERT = 3'd0,
      CMD_REMOVE = 3'd1,
      CMD_REACH  = 3'd2,
      CMD_CYCLE  = 3'd3,
      CMD_SCC    = 3'd4,
      CMD_LABEL  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_FWD   = 2'd0,
      MODE_CYC   = 2'd1,
      MODE_REV   = 2'd2,
      MODE_LBL   = 2'd3
   } mode_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [5:0] vertex_a;
      logic [5:0] vertex_b;
   } req_type;

   typedef struct packed {
      logic        flag;
      logic [12:0] count;
      logic [5:0]  vertex;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_EDIT_RD,
      ST_EDIT_WR,
      ST_CLEAR,
      ST_ROOT,
      ST_TOP_RD,
      ST_TOP_WAIT,
      ST_ROW_RD,
      ST_SCAN,
      ST_REV_RD,
      ST_REV_WAIT,
      ST_FIN_RD,
      ST_FIN_WAIT,
      ST_LBL_RD,
      ST_LBL_WAIT,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

// ===== rtl/digraph_matrix_query_engine.sv =====
// top level: command sequencer, walk stack and mark stores around the matrix
// insert and remove read the row, then write it back; label reads the label store;
// unused commands go straight to the response. reach, cycle and scc searches walk
//   a stack of vertices; each stack step costs a row read, the forward scan tests
//   one bit a cycle and the reverse pass reads one row for each bit that it tests
// throughput: one request at a time, req_ready is low while a command runs, a
//   response waits or reset clears the matrix, a pass over all 64 rows, one row a cycle
`default_nettype none
module digraph_matrix_query_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire dmq_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output dmq_pkg::rsp_type       rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [6:0]        csr_data
);
   import dmq_pkg::*;

   localparam int VW = VertexWidth;
   localparam int NW = VertexWidth + 1;

   state_type state_ff, state_in;
   logic [6:0] vcount_ff;
   logic [NW-1:0] n_eff;
   req_type req_ff;
   mode_type mode_ff, mode_in;
   logic [12:0] arcs_ff, arcs_in;
   logic [MaxVertices-1:0] visited_ff, finished_ff;
   logic [VW-1:0] label_mem [MaxVertices];
   logic [VW-1:0] fseq_mem [MaxVertices];
   logic [VW-1:0] stk_v [MaxVertices];
   logic [NW-1:0] stk_w [MaxVertices];
   logic [NW-1:0] depth_ff;
   logic [NW-1:0] root_ff;        // outer loop vertex or finish-sequence index
   logic [NW-1:0] fin_cnt_ff;
   logic [NW-1:0] scan_ff;        // current neighbour index
   logic [VW-1:0] cur_v_ff;
   logic [MaxVertices-1:0] row_ff; // row for scan (forward) snapshot
   logic [6:0] k_ff;
   logic flag_ff;
   logic [VW-1:0] vert_ff;
   logic [NW-1:0] clr_ff;
   logic clr_busy_ff;
   logic [MaxVertices-1:0] rd_data;
   logic mem_we;
   logic [VW-1:0] mem_wrow, mem_rrow;
   logic [MaxVertices-1:0] mem_wdata;
   logic [VW-1:0] lbl_rd_ff, fseq_rd_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   // effective vertex count
   always_comb begin
      if (vcount_ff == 7'd0) n_eff = NW'(1);
      else if (vcount_ff > 7'(MaxVertices)) n_eff = NW'(MaxVertices);
      else n_eff = NW'(vcount_ff);
   end

   dmq_matrix u_matrix (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_row  (mem_wrow),
      .wr_data (mem_wdata),
      .rd_row  (mem_rrow),
      .rd_data (rd_data)
   );

   assign csr_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff && !clr_busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   logic a_ok, b_ok;
   assign a_ok = {1'b0, req_ff.vertex_a} < n_eff;
   assign b_ok = {1'b0, req_ff.vertex_b} < n_eff;

   // bit at scan position of the row in hand
   logic bit_hit, w_in_range;
   logic [VW-1:0] scan_v;
   assign scan_v = scan_ff[VW-1:0];
   assign w_in_range = scan_ff < n_eff;
   assign bit_hit = row_ff[scan_v];

   // the reverse pass reads row w and tests bit cur_v; rd_data holds row w
   logic rev_bit;
   assign rev_bit = rd_data[cur_v_ff];

   logic top_done;
   assign top_done = (depth_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               case (req_data.cmd)
                  CMD_INSERT, CMD_REMOVE: state_in = ST_EDIT_RD;
                  CMD_REACH, CMD_CYCLE, CMD_SCC: state_in = ST_CLEAR;
                  CMD_LABEL: state_in = ST_LBL_RD;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_EDIT_RD:  state_in = ST_EDIT_WR;
         ST_EDIT_WR:  state_in = ST_DONE;
         ST_CLEAR: begin
            if (req_ff.cmd == CMD_REACH && !(a_ok && b_ok)) state_in = ST_DONE;
            else state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (mode_ff == MODE_LBL) begin
               if (root_ff == '0) state_in = ST_DONE;
               else state_in = ST_FIN_RD;
            end else if (root_ff >= n_eff || (mode_ff == MODE_FWD && root_ff != '0)) begin
               state_in = (mode_ff == MODE_REV) ? ST_CLEAR : ST_DONE;
            end else if (visited_ff[root_ff[VW-1:0]] && mode_ff != MODE_FWD) begin
               state_in = ST_ROOT;
            end else begin
               state_in = ST_TOP_RD;
            end
         end
         ST_FIN_RD:   state_in = ST_FIN_WAIT;
         ST_FIN_WAIT: begin
            if ({1'b0, fseq_rd_ff} < n_eff && !visited_ff[fseq_rd_ff]) state_in = ST_TOP_RD;
            else state_in = ST_ROOT;
         end
         ST_TOP_RD: begin
            if (top_done) state_in = ST_ROOT;
            else state_in = ST_TOP_WAIT;
         end
         ST_TOP_WAIT: state_in = (mode_ff == MODE_REV) ? ST_REV_RD : ST_ROW_RD;
         ST_ROW_RD:   state_in = ST_SCAN;
         ST_SCAN: begin
            if (!w_in_range) state_in = ST_TOP_RD;
            else if (bit_hit && !visited_ff[scan_v]) state_in = ST_TOP_RD;
            else if (bit_hit && mode_ff == MODE_CYC && !finished_ff[scan_v])
               state_in = ST_DONE;
         end
         ST_REV_RD:   state_in = ST_REV_WAIT;
         ST_REV_WAIT: begin
            if (!w_in_range) state_in = ST_TOP_RD;
            else if (rev_bit && !visited_ff[scan_v]) state_in = ST_TOP_RD;
            else state_in = ST_REV_RD;
         end
         ST_LBL_RD:   state_in = ST_LBL_WAIT;
         ST_LBL_WAIT: state_in = ST_DONE;
         ST_DONE:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // memory port selection
   always_comb begin
      mem_we    = 1'b0;
      mem_wrow  = req_ff.vertex_a;
      mem_wdata = rd_data;
      mem_rrow  = req_ff.vertex_a;
      if (clr_busy_ff) begin
         mem_we    = 1'b1;
         mem_wrow  = clr_ff[VW-1:0];
         mem_wdata = '0;
      end else if (state_ff == ST_EDIT_WR && a_ok && b_ok) begin
         mem_we = 1'b1;
         mem_wdata[req_ff.vertex_b] = (req_ff.cmd == CMD_INSERT);
      end
      if (state_ff == ST_ROW_RD || state_ff == ST_TOP_WAIT) mem_rrow = cur_v_ff;
      if (state_ff == ST_REV_RD) mem_rrow = scan_v;
   end

   logic edit_change;
   assign edit_change = a_ok && b_ok &&
      ((req_ff.cmd == CMD_INSERT) ? !rd_data[req_ff.vertex_b] : rd_data[req_ff.vertex_b]);

   always_comb begin
      mode_in = mode_ff;
      arcs_in = arcs_ff;
      if (state_ff == ST_EDIT_WR && edit_change) begin
         arcs_in = (req_ff.cmd == CMD_INSERT) ? arcs_ff + 13'd1 : arcs_ff - 13'd1;
      end
      if (state_ff == ST_IDLE && req_valid && req_ready) begin
         case (req_data.cmd)
            CMD_CYCLE: mode_in = MODE_CYC;
            CMD_SCC:   mode_in = MODE_REV;
            default:   mode_in = MODE_FWD;
         endcase
      end else if (state_ff == ST_ROOT && mode_ff == MODE_REV && root_ff >= n_eff) begin
         mode_in = MODE_LBL;
      end
   end

   // response fields per command
   always_comb begin
      rsp_in.flag   = flag_ff;
      rsp_in.count  = '0;
      rsp_in.vertex = vert_ff;
      case (req_ff.cmd)
         CMD_INSERT, CMD_REMOVE: rsp_in.count = arcs_ff;
         CMD_REACH: rsp_in.flag = a_ok && b_ok && visited_ff[req_ff.vertex_b];
         CMD_SCC: rsp_in.count = 13'(k_ff);
         CMD_LABEL: rsp_in.vertex = a_ok ? lbl_rd_ff : '0;
         CMD_CYCLE: ;
         default: begin
            rsp_in.flag   = 1'b0;
            rsp_in.vertex = '0;
         end
      endcase
   end

   // sequencer datapath
   logic [VW-1:0] push_v;
   assign push_v = (mode_ff == MODE_FWD) ? req_ff.vertex_a : root_ff[VW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcount_ff    <= 7'd64;
         arcs_ff      <= '0;
         mode_ff      <= MODE_FWD;
         depth_ff     <= '0;
         clr_ff       <= '0;
         clr_busy_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         arcs_ff  <= arcs_in;
         if (clr_busy_ff) begin
            clr_ff <= clr_ff + NW'(1);
            if (clr_ff == NW'(MaxVertices - 1)) clr_busy_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) vcount_ff <= csr_data;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_DONE) rsp_valid_ff <= 1'b1;
         case (state_ff)
            ST_TOP_RD: begin
               if (!top_done) begin
                  cur_v_ff <= stk_v[depth_ff[VW-1:0] - VW'(1)];
                  scan_ff  <= stk_w[depth_ff[VW-1:0] - VW'(1)];
               end
            end
            ST_SCAN: begin
               if (!w_in_range) begin
                  depth_ff <= depth_ff - NW'(1);
               end else if (bit_hit && !visited_ff[scan_v]) begin
                  depth_ff <= depth_ff + NW'(1);
               end else begin
                  scan_ff <= scan_ff + NW'(1);
               end
            end
            ST_REV_WAIT: begin
               if (!w_in_range) depth_ff <= depth_ff - NW'(1);
               else if (rev_bit && !visited_ff[scan_v]) depth_ff <= depth_ff + NW'(1);
               else scan_ff <= scan_ff + NW'(1);
            end
            ST_ROOT: begin
               if (mode_ff != MODE_LBL && root_ff < n_eff &&
                   !(mode_ff == MODE_FWD && root_ff != '0) &&
                   !(visited_ff[root_ff[VW-1:0]] && mode_ff != MODE_FWD)) begin
                  depth_ff <= NW'(1);
               end
            end
            ST_FIN_WAIT: begin
               if ({1'b0, fseq_rd_ff} < n_eff && !visited_ff[fseq_rd_ff]) begin
                  depth_ff <= NW'(1);
               end
            end
            default: ;
         endcase
      end
   end

   // payload registers and stores
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid && req_ready) req_ff <= req_data;
      if (state_ff == ST_TOP_WAIT || state_ff == ST_ROW_RD) row_ff <= rd_data;
      lbl_rd_ff  <= label_mem[req_ff.vertex_a];
      fseq_rd_ff <= fseq_mem[root_ff[VW-1:0] - VW'(1)];
      case (state_ff)
         ST_IDLE: begin
            flag_ff <= 1'b0;
            vert_ff <= '0;
         end
         ST_CLEAR: begin
            visited_ff  <= '0;
            finished_ff <= '0;
            fin_cnt_ff  <= '0;
            k_ff        <= '0;
            root_ff     <= (mode_ff == MODE_LBL) ? n_eff :
                           (mode_ff == MODE_FWD) ? NW'(0) : NW'(0);
         end
         ST_ROOT: begin
            if (mode_ff == MODE_REV && root_ff >= n_eff) begin
               root_ff    <= n_eff;
               visited_ff <= '0;
               finished_ff <= '0;
            end else if (mode_ff != MODE_LBL && root_ff < n_eff &&
                         !(mode_ff == MODE_FWD && root_ff != '0) &&
                         !(visited_ff[root_ff[VW-1:0]] && mode_ff != MODE_FWD)) begin
               visited_ff[push_v]  <= 1'b1;
               finished_ff[push_v] <= 1'b0;
               stk_v[0] <= push_v;
               stk_w[0] <= '0;
               root_ff  <= root_ff + NW'(1);
            end else if (mode_ff != MODE_LBL) begin
               root_ff <= root_ff + NW'(1);
            end
         end
         ST_FIN_WAIT: begin
            root_ff <= root_ff - NW'(1);
            if ({1'b0, fseq_rd_ff} < n_eff && !visited_ff[fseq_rd_ff]) begin
               visited_ff[fseq_rd_ff] <= 1'b1;
               label_mem[fseq_rd_ff]  <= k_ff[VW-1:0];
               stk_v[0] <= fseq_rd_ff;
               stk_w[0] <= '0;
               k_ff <= k_ff + 7'd1;
            end
         end
         ST_SCAN: begin
            if (!w_in_range) begin
               finished_ff[cur_v_ff] <= 1'b1;
               fin_cnt_ff <= fin_cnt_ff + NW'(1);
            end else if (bit_hit && !visited_ff[scan_v]) begin
               stk_w[depth_ff[VW-1:0] - VW'(1)] <= scan_ff + NW'(1);
               visited_ff[scan_v]  <= 1'b1;
               finished_ff[scan_v] <= 1'b0;
               if (mode_ff == MODE_LBL) label_mem[scan_v] <= k_ff[VW-1:0] - VW'(1);
               stk_v[depth_ff[VW-1:0]] <= scan_v;
               stk_w[depth_ff[VW-1:0]] <= '0;
            end else if (bit_hit && mode_ff == MODE_CYC && !finished_ff[scan_v]) begin
               flag_ff <= 1'b1;
               vert_ff <= scan_v;
            end
         end
         ST_REV_WAIT: begin
            if (!w_in_range) begin
               finished_ff[cur_v_ff] <= 1'b1;
               fseq_mem[fin_cnt_ff[VW-1:0]] <= cur_v_ff;
               fin_cnt_ff <= fin_cnt_ff + NW'(1);
            end else if (rev_bit && !visited_ff[scan_v]) begin
               stk_w[depth_ff[VW-1:0] - VW'(1)] <= scan_ff + NW'(1);
               visited_ff[scan_v] <= 1'b1;
               stk_v[depth_ff[VW-1:0]] <= scan_v;
               stk_w[depth_ff[VW-1:0]] <= '0;
            end
         end
         ST_EDIT_WR: flag_ff <= edit_change;
         ST_DONE: rsp_ff <= rsp_in;
         default: ;
      endcase
   end

`ifndef NO_ASSERTIONS
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("ready while busy");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_valid) else $error("missing response");
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= NW'(MaxVertices)) else $error("stack overflow");
   a_no_cfg_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !csr_ready) else $error("config during response");
`endif
endmodule
`default_nettype wire

// ===== rtl/dmq_matrix.sv =====
// adjacency matrix memory, one row written and one row read per cycle
`default_nettype none
module dmq_matrix (
   input  wire logic                               clock,
   input  wire logic                               wr_en,
   input  wire logic [dmq_pkg::VertexWidth-1:0]    wr_row,
   input  wire logic [dmq_pkg::MaxVertices-1:0]    wr_data,
   input  wire logic [dmq_pkg::VertexWidth-1:0]    rd_row,
   output logic      [dmq_pkg::MaxVertices-1:0]    rd_data
);
   import dmq_pkg::*;

   logic [MaxVertices-1:0] mem [MaxVertices];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row] <= wr_data;
      end
      rd_data <= mem[rd_row];
   end
endmodule
`default_nettype wire
